>>> rtl/arp_pkg.sv
// Shared constants, codes and helpers of the aging resource pool.
package arp_pkg;

  localparam int NUM_BUCKETS      = 8;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;

  localparam int BIDX_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SIDX_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SLOT_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int CNT_W   = 6;
  localparam int AGE_W   = 8;
  localparam int ROW_W   = SLOTS_PER_BUCKET * AGE_W;

  localparam int DIM_W    = 14;
  localparam int CODE_W   = 16;
  localparam int SIZE_W   = 2 * DIM_W;
  localparam int FMT_W    = 3 * CODE_W;
  localparam int KEY_W    = SIZE_W + FMT_W;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 3;

  localparam int S_DATA_W = 88;
  localparam int M_DATA_W = 24;

  localparam logic [AGE_W-1:0] MISS_RESET = 8'd10;
  localparam logic [AGE_W-1:0] IDLE_RESET = 8'd20;
  localparam logic [AGE_W-1:0] AGE_MAX    = 8'd255;

  localparam logic CFG_MISS_LIMIT = 1'b0;
  localparam logic CFG_IDLE_LIMIT = 1'b1;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLAIMED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
    sat_inc = (v == AGE_MAX) ? AGE_MAX : v + AGE_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [BIDX_W-1:0] b, input int s);
    slot_of = SLOT_W'(int'(b) * SLOTS_PER_BUCKET + s);
  endfunction

endpackage

>>> rtl/arp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/aging_resource_pool_unit.sv
// Aging resource pool: buffer handle allocator with bucket and idle aging.
//
// Input channel s_*: one transfer is one request. s_tuser carries the kind
// (acquire or release); s_tdata carries the bucket key and the handle to
// release. Output channel m_*: one result transfer per request, with the
// granted handle, a status code and the total and busy slot counts.
// cfg_we/cfg_addr/cfg_data write the miss limit (index 0) and idle limit
// (index 1); write only while the block is idle.
//
// One request at a time. An acquire runs from its transfer to the result
// through these steps: a walk of the key memory one bucket per cycle, bucket
// aging, opening a bucket, if one is found a read-modify-write of its idle-age row,
// a count walk over the buckets one bucket per cycle and posting the result.
// A release skips the key walk, aging and opening. The next request is taken
// only once the result is posted, so no request is taken before the last one
// is through. The key walk and the count walk make up most of a request.
//
// Reset (rst, synchronous) empties the pool and restores both limits; the
// memories are not cleared, as no entry is used before it is written.
// If the receiver stalls, the result is held in the output register and
// the block waits before posting the next one.
module aging_resource_pool_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // width, height, internal_fmt, pixel_fmt, elem_type, handle_in, handle_ok
  input  logic [arp_pkg::S_DATA_W-1:0]   s_tdata,
  // kind
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // handle_out, status, total_count, busy_count
  output logic [arp_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [arp_pkg::AGE_W-1:0]      cfg_data
);

  localparam int NB = arp_pkg::NUM_BUCKETS;
  localparam int NS = arp_pkg::SLOTS_PER_BUCKET;
  localparam int NT = arp_pkg::TOTAL_SLOTS;
  localparam int BW = arp_pkg::BIDX_W;
  localparam int AW = arp_pkg::AGE_W;
  localparam int CW = arp_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LAST, S_AGE, S_OPEN, S_ROW, S_SLOT, S_REL, S_COUNT, S_DONE
  } state_t;

  state_t state;

  // limits
  logic [AW-1:0] miss_limit, idle_limit;

  // request
  logic                       op_kind;
  logic [arp_pkg::KEY_W-1:0]  key;
  logic [arp_pkg::HANDLE_W-1:0] rel_handle;
  logic                       rel_ok;

  // pool state held in flops
  logic          bvalid  [NB];
  logic [AW-1:0] miss    [NB];
  logic          present [NT];
  logic          busy    [NT];

  // key walk
  logic [BW-1:0] scan_idx, cmp_idx, cur_b;
  logic          cmp_vld;
  logic          hit_found;
  logic [BW-1:0] hit_idx;

  // result and counting
  logic [arp_pkg::HANDLE_W-1:0] res_handle;
  logic [arp_pkg::STATUS_W-1:0] res_status;
  logic [BW-1:0] cnt_idx;
  logic [CW-1:0] tot_acc, busy_acc;

  // memories
  logic                      key_we;
  logic [arp_pkg::KEY_W-1:0] key_rdata;
  logic                      row_we;
  logic [arp_pkg::ROW_W-1:0] row_rdata, row_wdata;

  // lowest free bucket after aging
  logic          open_found;
  logic [BW-1:0] open_idx;

  arp_ram #(.WIDTH(arp_pkg::KEY_W), .DEPTH(NB)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(open_idx), .wdata(key),
    .raddr(scan_idx), .rdata(key_rdata)
  );

  arp_ram #(.WIDTH(arp_pkg::ROW_W), .DEPTH(NB)) u_age_ram (
    .clk(clk), .we(row_we), .waddr(cur_b), .wdata(row_wdata),
    .raddr(cur_b), .rdata(row_rdata)
  );

  assign s_tready = (state == S_IDLE);

  // Bucket aging: every valid bucket other than the hit is a miss.
  logic          age_valid   [NB];
  logic [AW-1:0] age_miss    [NB];
  logic          age_present [NT];

  always_comb begin
    logic [AW-1:0] inc;
    logic          frees;
    logic          any;
    any = 1'b0;
    for (int b = 0; b < NB; b++) begin
      age_valid[b] = bvalid[b];
      age_miss[b]  = miss[b];
      for (int s = 0; s < NS; s++) begin
        age_present[b*NS+s] = present[b*NS+s];
      end
      inc   = arp_pkg::sat_inc(miss[b]);
      frees = (inc >= miss_limit);
      if (hit_found && hit_idx == BW'(b)) begin
        age_miss[b] = '0;
      end else if (bvalid[b]) begin
        any = 1'b0;
        for (int s = 0; s < NS; s++) begin
          if (frees && !busy[b*NS+s]) begin
            age_present[b*NS+s] = 1'b0;
          end
          any = any | age_present[b*NS+s];
        end
        age_miss[b] = frees ? '0 : inc;
        if (!any) begin
          age_valid[b] = 1'b0;
          age_miss[b]  = '0;
        end
      end
    end
  end

  always_comb begin
    open_found = 1'b0;
    open_idx   = '0;
    for (int b = NB - 1; b >= 0; b--) begin
      if (!bvalid[b]) begin
        open_found = 1'b1;
        open_idx   = BW'(b);
      end
    end
  end

  // Slot pick and idle aging inside bucket cur_b.
  logic                         pick_found, pick_claim;
  logic [arp_pkg::SIDX_W-1:0]   pick_s;
  logic                         slot_present_n [NS];
  logic                         slot_busy_n    [NS];
  logic [arp_pkg::ROW_W-1:0]    slot_row_n;

  always_comb begin
    logic [AW-1:0] age;
    logic          idle_found;
    logic          free_found;
    logic [arp_pkg::SIDX_W-1:0] idle_s, free_s;
    idle_found = 1'b0;
    free_found = 1'b0;
    idle_s     = '0;
    free_s     = '0;
    for (int s = NS - 1; s >= 0; s--) begin
      if (present[arp_pkg::slot_of(cur_b, s)] && !busy[arp_pkg::slot_of(cur_b, s)]) begin
        idle_found = 1'b1;
        idle_s     = arp_pkg::SIDX_W'(s);
      end
      if (!present[arp_pkg::slot_of(cur_b, s)]) begin
        free_found = 1'b1;
        free_s     = arp_pkg::SIDX_W'(s);
      end
    end
    pick_claim = !idle_found;
    pick_found = idle_found || free_found;
    pick_s     = idle_found ? idle_s : free_s;
    slot_row_n = row_rdata;
    for (int s = 0; s < NS; s++) begin
      slot_present_n[s] = present[arp_pkg::slot_of(cur_b, s)];
      slot_busy_n[s]    = busy[arp_pkg::slot_of(cur_b, s)];
      age = arp_pkg::sat_inc(row_rdata[s*AW +: AW]);
      if (pick_s == arp_pkg::SIDX_W'(s)) begin
        slot_present_n[s]   = 1'b1;
        slot_busy_n[s]      = 1'b1;
        slot_row_n[s*AW +: AW] = '0;
      end else if (slot_present_n[s] && !slot_busy_n[s]) begin
        if (age >= idle_limit) begin
          slot_present_n[s]      = 1'b0;
          slot_row_n[s*AW +: AW] = '0;
        end else begin
          slot_row_n[s*AW +: AW] = age;
        end
      end
    end
  end

  // release checks
  logic [arp_pkg::SIDX_W-1:0] rel_s;
  logic                       rel_valid;
  logic [arp_pkg::ROW_W-1:0]  rel_row_n;

  assign rel_s     = arp_pkg::SIDX_W'(rel_handle % NS);
  assign rel_valid = rel_ok
                     && ({1'b0, rel_handle} < (arp_pkg::HANDLE_W + 1)'(NT))
                     && present[arp_pkg::SLOT_W'(rel_handle)];

  always_comb begin
    rel_row_n = row_rdata;
    rel_row_n[rel_s*AW +: AW] = '0;
  end

  assign key_we    = (state == S_OPEN) && !hit_found && open_found;
  assign row_we    = ((state == S_SLOT) && pick_found) || ((state == S_REL) && rel_valid);
  assign row_wdata = (state == S_REL) ? rel_row_n : slot_row_n;

  // per-bucket occupancy for the count walk
  logic [CW-1:0] bkt_tot, bkt_busy;

  always_comb begin
    bkt_tot  = '0;
    bkt_busy = '0;
    for (int s = 0; s < NS; s++) begin
      bkt_tot  = bkt_tot + CW'(present[arp_pkg::slot_of(cnt_idx, s)]);
      bkt_busy = bkt_busy + CW'(present[arp_pkg::slot_of(cnt_idx, s)]
                                && busy[arp_pkg::slot_of(cnt_idx, s)]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      miss_limit <= arp_pkg::MISS_RESET;
      idle_limit <= arp_pkg::IDLE_RESET;
      m_tvalid   <= 1'b0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      for (int b = 0; b < NB; b++) begin
        bvalid[b] <= 1'b0;
        miss[b]   <= '0;
      end
      for (int g = 0; g < NT; g++) begin
        present[g] <= 1'b0;
        busy[g]    <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_addr == arp_pkg::CFG_MISS_LIMIT) begin
          miss_limit <= cfg_data;
        end else begin
          idle_limit <= cfg_data;
        end
      end
      // S_DONE refills the output register itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      // key compare in the cycle after the read
      cmp_vld <= (state == S_SCAN);
      if (cmp_vld && !hit_found && bvalid[cmp_idx] && key_rdata == key) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_kind    <= s_tuser;
            key        <= s_tdata[arp_pkg::KEY_W-1:0];
            rel_handle <= s_tdata[arp_pkg::KEY_W +: arp_pkg::HANDLE_W];
            rel_ok     <= s_tdata[arp_pkg::KEY_W + arp_pkg::HANDLE_W];
            cur_b      <= BW'(s_tdata[arp_pkg::KEY_W +: arp_pkg::HANDLE_W] / NS);
            scan_idx   <= '0;
            hit_found  <= 1'b0;
            res_handle <= '0;
            state      <= (s_tuser == arp_pkg::KIND_RELEASE) ? S_ROW : S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_idx <= scan_idx;
          if (scan_idx == BW'(NB - 1)) begin
            state <= S_LAST;
          end else begin
            scan_idx <= scan_idx + BW'(1);
          end
        end
        S_LAST: begin
          state <= S_AGE;
        end
        S_AGE: begin
          for (int b = 0; b < NB; b++) begin
            bvalid[b] <= age_valid[b];
            miss[b]   <= age_miss[b];
          end
          for (int g = 0; g < NT; g++) begin
            present[g] <= age_present[g];
          end
          state <= S_OPEN;
        end
        S_OPEN: begin
          if (hit_found) begin
            cur_b <= hit_idx;
            state <= S_ROW;
          end else if (open_found) begin
            // key written to the key memory at open_idx this cycle
            bvalid[open_idx] <= 1'b1;
            miss[open_idx]   <= '0;
            state            <= S_ROW;
          end else begin
            res_status <= arp_pkg::ST_NO_ROOM;
            cnt_idx    <= '0;
            tot_acc    <= '0;
            busy_acc   <= '0;
            state      <= S_COUNT;
          end
        end
        S_ROW: begin
          state <= (op_kind == arp_pkg::KIND_RELEASE) ? S_REL : S_SLOT;
        end
        S_SLOT: begin
          if (pick_found) begin
            for (int s = 0; s < NS; s++) begin
              present[arp_pkg::slot_of(cur_b, s)] <= slot_present_n[s];
              busy[arp_pkg::slot_of(cur_b, s)]    <= slot_busy_n[s];
            end
            res_handle <= arp_pkg::HANDLE_W'(arp_pkg::slot_of(cur_b, int'(pick_s)));
            res_status <= pick_claim ? arp_pkg::ST_CLAIMED : arp_pkg::ST_REUSED;
          end else begin
            res_status <= arp_pkg::ST_NO_ROOM;
          end
          cnt_idx  <= '0;
          tot_acc  <= '0;
          busy_acc <= '0;
          state    <= S_COUNT;
        end
        S_REL: begin
          if (rel_valid) begin
            busy[arp_pkg::SLOT_W'(rel_handle)] <= 1'b0;
            res_status <= arp_pkg::ST_RELEASED;
          end else begin
            res_status <= arp_pkg::ST_IGNORED;
          end
          cnt_idx  <= '0;
          tot_acc  <= '0;
          busy_acc <= '0;
          state    <= S_COUNT;
        end
        S_COUNT: begin
          tot_acc  <= tot_acc + bkt_tot;
          busy_acc <= busy_acc + bkt_busy;
          if (cnt_idx == BW'(NB - 1)) begin
            state <= S_DONE;
          end else begin
            cnt_idx <= cnt_idx + BW'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, busy_acc, tot_acc, res_status, res_handle};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // the open bucket index rides on cur_b for the row access
      if (state == S_OPEN && !hit_found && open_found) begin
        cur_b <= open_idx;
      end
    end
  end

endmodule

>>> rtl/arp_chk.sv
// Port-level checks of the aging resource pool, bound to the top level.
module arp_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [arp_pkg::M_DATA_W-1:0] m_tdata
);

  logic [arp_pkg::HANDLE_W-1:0] handle;
  logic [arp_pkg::STATUS_W-1:0] status;
  logic [arp_pkg::CNT_W-1:0]    total, busy;

  assign handle = m_tdata[4:0];
  assign status = m_tdata[7:5];
  assign total  = m_tdata[13:8];
  assign busy   = m_tdata[19:14];

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> busy <= total && total <= arp_pkg::CNT_W'(arp_pkg::TOTAL_SLOTS))
    else $error("busy/total counts inconsistent");

  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != arp_pkg::ST_REUSED && status != arp_pkg::ST_CLAIMED
    |-> handle == '0)
    else $error("handle set without a grant");

  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == arp_pkg::ST_REUSED || status == arp_pkg::ST_CLAIMED)
    |-> busy != '0)
    else $error("grant reported with no busy slot");

endmodule

bind aging_resource_pool_unit arp_chk u_arp_chk (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> test/aging_resource_pool_unit_test.sv
// Self-checking regression of the aging resource pool unit.
module aging_resource_pool_unit_test;
  import arp_pkg::*;

  // Request after its kind, lowest bus field first; result highest field first.
  typedef struct {
    logic        kind;
    logic [13:0] wid;
    logic [13:0] hgt;
    logic [15:0] ifmt;
    logic [15:0] pfmt;
    logic [15:0] etype;
    logic [4:0]  hin;
    logic        hok;
  } req_t;

  typedef struct packed {
    logic [5:0]          busy;
    logic [5:0]          total;
    logic [STATUS_W-1:0] status;
    logic [4:0]          handle;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [AGE_W-1:0] cfg_data = '0;

  aging_resource_pool_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: a private copy of the pool.
  logic [7:0]  miss_lim, idle_lim;
  logic        bkt_on   [NUM_BUCKETS];
  logic [27:0] bkt_size [NUM_BUCKETS];
  logic [47:0] bkt_fmt  [NUM_BUCKETS];
  logic [7:0]  bkt_miss [NUM_BUCKETS];
  logic        slot_held[TOTAL_SLOTS];
  logic        slot_out [TOTAL_SLOTS];
  logic [7:0]  slot_age [TOTAL_SLOTS];

  res_t expected_results[$];
  int   errors = 0;
  int   idle_in_pct = 0;   // sender gap chance
  int   stall_pct = 0;     // receiver stall chance
  int   quiet = 0;         // cycles with no transfer on either side

  function automatic logic [7:0] bump(logic [7:0] v);
    return (v == 8'd255) ? v : v + 8'd1;
  endfunction

  function automatic logic bucket_idle_all(int b);
    for (int s = 0; s < SLOTS_PER_BUCKET; s++)
      if (slot_held[b*SLOTS_PER_BUCKET+s]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic pool_reset();
    miss_lim = MISS_RESET;
    idle_lim = IDLE_RESET;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      bkt_on[b] = 0; bkt_size[b] = 0; bkt_fmt[b] = 0; bkt_miss[b] = 0;
    end
    for (int g = 0; g < TOTAL_SLOTS; g++) begin
      slot_held[g] = 0; slot_out[g] = 0; slot_age[g] = 0;
    end
  endtask

  // Works out the result of one request and updates the copy of the pool.
  function automatic res_t pool_predict(req_t r);
    res_t  o;
    int    hit, pick, g, tot, bsy;
    logic  claimed;
    logic [27:0] sk;
    logic [47:0] fk;
    o = '0;
    o.status = ST_IGNORED;
    hit = -1; pick = -1; claimed = 0;
    sk = {r.wid, r.hgt};
    fk = {r.ifmt, r.pfmt, r.etype};
    if (r.kind == KIND_ACQUIRE) begin
      for (int b = 0; b < NUM_BUCKETS; b++)
        if (hit < 0 && bkt_on[b] && bkt_size[b] == sk && bkt_fmt[b] == fk) hit = b;
      if (hit >= 0) bkt_miss[hit] = 0;
      // every other bucket in use takes a miss
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        if (b == hit || !bkt_on[b]) continue;
        bkt_miss[b] = bump(bkt_miss[b]);
        if (bkt_miss[b] >= miss_lim) begin
          for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            g = b*SLOTS_PER_BUCKET + s;
            if (slot_held[g] && !slot_out[g]) begin slot_held[g] = 0; slot_age[g] = 0; end
          end
          bkt_miss[b] = 0;
        end
        if (bucket_idle_all(b)) begin bkt_on[b] = 0; bkt_miss[b] = 0; end
      end
      o.status = ST_NO_ROOM;
      if (hit < 0) begin
        for (int b = 0; b < NUM_BUCKETS; b++) if (hit < 0 && !bkt_on[b]) hit = b;
        if (hit >= 0) begin
          bkt_on[hit] = 1; bkt_size[hit] = sk; bkt_fmt[hit] = fk; bkt_miss[hit] = 0;
        end
      end
      if (hit >= 0) begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
          g = hit*SLOTS_PER_BUCKET + s;
          if (pick < 0 && slot_held[g] && !slot_out[g]) pick = g;
        end
        if (pick < 0) begin
          claimed = 1;
          for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            g = hit*SLOTS_PER_BUCKET + s;
            if (pick < 0 && !slot_held[g]) pick = g;
          end
        end
        if (pick >= 0) begin
          slot_held[pick] = 1; slot_out[pick] = 1; slot_age[pick] = 0;
          for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            g = hit*SLOTS_PER_BUCKET + s;
            if (slot_held[g] && !slot_out[g]) begin
              slot_age[g] = bump(slot_age[g]);
              if (slot_age[g] >= idle_lim) begin slot_held[g] = 0; slot_age[g] = 0; end
            end
          end
          o.handle = pick[4:0];
          o.status = claimed ? ST_CLAIMED : ST_REUSED;
        end
      end
    end else if (r.hok && r.hin < TOTAL_SLOTS && slot_held[r.hin]) begin
      slot_out[r.hin] = 0; slot_age[r.hin] = 0;
      o.status = ST_RELEASED;
    end
    tot = 0; bsy = 0;
    for (int i = 0; i < TOTAL_SLOTS; i++)
      if (slot_held[i]) begin tot++; if (slot_out[i]) bsy++; end
    o.total = tot[5:0];
    o.busy = bsy[5:0];
    return o;
  endfunction

  // Sends one request; the prediction is queued at the transfer edge.
  // s_tvalid stays high after the transfer until the next request, a gap or a drain.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_in_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= {r.hok, r.hin, r.etype, r.pfmt, r.ifmt, r.hgt, r.wid};
    s_tuser  <= r.kind;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.insert(expected_results.size(), pool_predict(r));
    @(negedge clk);
  endtask

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // Result checker and watchdog.
  always @(posedge clk) begin
    res_t got, exp_r;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[19:0]);
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", m_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.handle !== exp_r.handle) begin
            $error("handle_out exp %0d got %0d", exp_r.handle, got.handle); errors++;
          end
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.total !== exp_r.total) begin
            $error("total_count exp %0d got %0d", exp_r.total, got.total); errors++;
          end
          if (got.busy !== exp_r.busy) begin
            $error("busy_count exp %0d got %0d", exp_r.busy, got.busy); errors++;
          end
        end
      end
      // slowest transfer plus long runs of stalls stays well below this limit
      if (quiet > 5000) begin
        $display("aging_resource_pool_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic req_t acquire_of(int k);
    req_t r;
    r = '{KIND_ACQUIRE, 14'(k * 37), 14'(k), 16'(k * 3), 16'h0101, 16'(k), 5'd0, 1'b0};
    return r;
  endfunction

  function automatic req_t release_of(int h, logic ok);
    req_t r;
    r = '{KIND_RELEASE, 14'($urandom), 14'($urandom), 16'($urandom), 16'($urandom),
          16'($urandom), 5'(h), ok};
    return r;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_limit(logic idx, logic [7:0] v);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_MISS_LIMIT) miss_lim = v; else idle_lim = v;
  endtask

  // Directed: field extremes, bucket and pool full, bad releases, idle release.
  task automatic test_directed();
    req_t r;
    r = '{KIND_ACQUIRE, 14'h3FFF, 14'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 1'b1};
    send_request(r);
    r = '{KIND_ACQUIRE, 14'h0, 14'h0, 16'h0, 16'h0, 16'h0, 5'd0, 1'b0};
    send_request(r);
    for (int i = 0; i < 4; i++) send_request(acquire_of(1));   // bucket full after the fourth
    for (int k = 2; k < 9; k++) send_request(acquire_of(k));   // pool runs out of buckets
    send_request(release_of(0, 1'b0));                         // not valid
    send_request(release_of(31, 1'b1));                        // slot never held
    send_request(release_of(8, 1'b1));
    send_request(release_of(8, 1'b1));                         // already idle
    send_request(acquire_of(1));                               // reuses it
    send_request(release_of(9, 1'b1));
    send_request(release_of(4, 1'b1));
    for (int i = 0; i < 3; i++) send_request(acquire_of(2));
  endtask

  task automatic test_limits(logic [7:0] ml, logic [7:0] il, int n);
    drain();
    write_limit(CFG_MISS_LIMIT, ml);
    write_limit(CFG_IDLE_LIMIT, il);
    test_random(n);
  endtask

  // Mostly acquires on a few keys and releases of random handles; some noise.
  task automatic test_random(int n);
    req_t r;
    int   pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) r = acquire_of($urandom_range(11));
      else if (pick < 88) r = release_of($urandom_range(31), 1'b1);
      else r = '{1'($urandom), 14'($urandom), 14'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 5'($urandom), 1'($urandom)};
      send_request(r);
    end
  endtask

  initial begin
    pool_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(127);
    idle_in_pct = 77;
    test_limits(8'd1, 8'd255, 70);
    idle_in_pct = 0; stall_pct = 77;
    test_limits(8'd255, 8'd1, 70);
    idle_in_pct = 23; stall_pct = 23;
    test_limits(8'd3, 8'd4, 80);
    idle_in_pct = 0; stall_pct = 0;
    test_limits(8'd6, 8'd2, 80);
    drain();
    if (errors == 0) $display("aging_resource_pool_unit regression: pass");
    else $display("aging_resource_pool_unit regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/arp_pkg.sv
rtl/arp_ram.sv
rtl/aging_resource_pool_unit.sv
rtl/arp_chk.sv
test/aging_resource_pool_unit_test.sv
